/* design/sau_pkg.sv */
// Shared types, constants and helper functions for the spherical-angle block.
// No dependencies; every other design file imports this package.
`default_nettype none

package sau_pkg;

    localparam int ANG_W      = 17;         // Q9.7 degrees, signed
    localparam int OUT_W      = 16;         // Q1.15, signed
    localparam int XY_W       = 33;         // CORDIC x/y, Q2.30 plus headroom
    localparam int Z_W        = 32;         // CORDIC residual angle
    localparam int ATAN_W     = 30;
    localparam int WIDE_W     = 36;         // width fed to rounding helpers
    localparam int MAX_STAGES = 24;

    localparam int FULL_TURN  = 46080;      // 360 deg in Q9.7
    localparam int GAIN_Q30   = 652032874;  // 1/K in Q2.30
    // binary angle = a*QUO + floor((a*REM + RND) / DIV45)
    localparam int QUO        = 93206;
    localparam int REM        = 34;
    localparam int RND        = 22;
    localparam int DIV45      = 45;
    localparam longint RECIP  = 64'd95443717;  // floor(2^32 / 45)

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [1:0]             quad;
    } cordic_t;

    function automatic logic [ATAN_W-1:0] cordic_atan(input int idx);
        logic [ATAN_W-1:0] v;
        begin
            case (idx)
                0:       v = 30'd536870912;
                1:       v = 30'd316933406;
                2:       v = 30'd167458907;
                3:       v = 30'd85004756;
                4:       v = 30'd42667331;
                5:       v = 30'd21354465;
                6:       v = 30'd10679838;
                7:       v = 30'd5340245;
                8:       v = 30'd2670163;
                9:       v = 30'd1335087;
                10:      v = 30'd667544;
                11:      v = 30'd333772;
                12:      v = 30'd166886;
                13:      v = 30'd83443;
                14:      v = 30'd41722;
                15:      v = 30'd20861;
                16:      v = 30'd10430;
                17:      v = 30'd5215;
                18:      v = 30'd2608;
                19:      v = 30'd1304;
                20:      v = 30'd652;
                21:      v = 30'd326;
                22:      v = 30'd163;
                23:      v = 30'd81;
                default: v = 30'd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [OUT_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        begin
            if (v > 36'sd32767)
                r = 16'sh7FFF;
            else if (v < -36'sd32768)
                r = 16'sh8000;
            else
                r = v[OUT_W-1:0];
            return r;
        end
    endfunction

    // floor((v + 2^14) / 2^15), saturated
    function automatic logic signed [OUT_W-1:0] rnd15_sat(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] s;
        begin
            s = (v + 36'sd16384) >>> 15;
            return sat16(s);
        end
    endfunction

    // negate with -32768 clipping to +32767
    function automatic logic signed [OUT_W-1:0] neg_sat(input logic signed [OUT_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        begin
            if (v == 16'sh8000)
                r = 16'sh7FFF;
            else
                r = -v;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

/* design/sau_angle_map.sv */
// Angle front end: reduces Q9.7 degrees mod 360 and maps to a 32-bit binary angle.
// Four register stages; output is the loaded CORDIC vector. Depends on sau_pkg.
`default_nettype none

module sau_angle_map (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic signed [sau_pkg::ANG_W-1:0] ang,
    output sau_pkg::cordic_t                 vec
);
    import sau_pkg::*;

    logic [15:0]    a_reg, a_next;
    logic [31:0]    p1_reg, p1_next, p1b_reg;
    logic [20:0]    t_reg, t_next, tb_reg;
    logic [15:0]    q1_reg, q1_next;
    cordic_t        vec_reg, vec_next;

    logic signed [ANG_W:0] v_ext, v_red;
    logic [47:0]    prod;
    logic [20:0]    rem;
    logic [15:0]    qq;
    logic [31:0]    bang;

    // stage 1: fold into 0..46079
    always_comb
    begin
        v_ext = (ANG_W+1)'(ang);
        if (v_ext < -18'sd46080)
            v_red = v_ext + 18'sd92160;
        else if (v_ext < 18'sd0)
            v_red = v_ext + 18'sd46080;
        else if (v_ext >= 18'sd46080)
            v_red = v_ext - 18'sd46080;
        else
            v_red = v_ext;
        a_next = v_red[15:0];
    end

    // stage 2: integer part of a*2^22/45 and the small remainder term
    always_comb
    begin
        p1_next = 32'(a_reg) * 32'(QUO);
        t_next  = 21'(a_reg) * 21'(REM) + 21'(RND);
    end

    // stage 3: reciprocal estimate, at most one low
    always_comb
    begin
        prod    = 48'(t_reg) * 48'(RECIP);
        q1_next = prod[47:32];
    end

    // stage 4: correction, final angle, CORDIC load
    always_comb
    begin
        rem  = tb_reg - 21'(q1_reg) * 21'(DIV45);
        qq   = (rem >= 21'(DIV45)) ? q1_reg + 16'd1 : q1_reg;
        bang = p1b_reg + 32'(qq);
        vec_next.x    = XY_W'(GAIN_Q30);
        vec_next.y    = '0;
        vec_next.z    = Z_W'({2'b00, bang[29:0]});
        vec_next.quad = bang[31:30];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= a_next;
            p1_reg  <= p1_next;
            t_reg   <= t_next;
            p1b_reg <= p1_reg;
            tb_reg  <= t_reg;
            q1_reg  <= q1_next;
            vec_reg <= vec_next;
        end
    end

    assign vec = vec_reg;

endmodule

`default_nettype wire

/* design/sau_cordic_stage.sv */
// One registered rotation-mode CORDIC micro-rotation, shift amount STAGE.
// Depends on sau_pkg for the vector type and arctangent table.
`default_nettype none

module sau_cordic_stage #(
    parameter int STAGE = 0
) (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire sau_pkg::cordic_t d,
    output sau_pkg::cordic_t     q
);
    import sau_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = Z_W'(cordic_atan(STAGE));

    logic signed [XY_W-1:0] xi, yi, dx, dy;
    logic signed [Z_W-1:0]  zi;
    cordic_t                q_reg, q_next;

    always_comb
    begin
        xi = d.x;
        yi = d.y;
        zi = d.z;
        dx = yi >>> STAGE;   // floor shift
        dy = xi >>> STAGE;
        q_next.quad = d.quad;
        if (!zi[Z_W-1])
        begin
            q_next.x = xi - dx;
            q_next.y = yi + dy;
            q_next.z = zi - ATAN;
        end
        else
        begin
            q_next.x = xi + dx;
            q_next.y = yi - dy;
            q_next.z = zi + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

/* design/sau_sincos.sv */
// Sine/cosine lane: angle map, NSTG CORDIC stages, then round and quadrant fold.
// Depends on sau_pkg, sau_angle_map, sau_cordic_stage.
`default_nettype none

module sau_sincos #(
    parameter int NSTG = 16
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [sau_pkg::ANG_W-1:0]  ang,
    output logic signed [sau_pkg::OUT_W-1:0]       sin_q,
    output logic signed [sau_pkg::OUT_W-1:0]       cos_q
);
    import sau_pkg::*;

    cordic_t stg [0:NSTG];

    logic signed [OUT_W-1:0] c_r, s_r;
    logic signed [OUT_W-1:0] sin_reg, sin_next, cos_reg, cos_next;

    sau_angle_map u_map (
        .clk (clk),
        .en  (en),
        .ang (ang),
        .vec (stg[0])
    );

    for (genvar i = 0; i < NSTG; i++)
    begin : g_stage
        sau_cordic_stage #(.STAGE(i)) u_stage (
            .clk (clk),
            .en  (en),
            .d   (stg[i]),
            .q   (stg[i+1])
        );
    end

    always_comb
    begin
        c_r = rnd15_sat(WIDE_W'(stg[NSTG].x));
        s_r = rnd15_sat(WIDE_W'(stg[NSTG].y));
        case (stg[NSTG].quad)
            2'd0:
            begin
                cos_next = c_r;
                sin_next = s_r;
            end
            2'd1:
            begin
                cos_next = neg_sat(s_r);
                sin_next = c_r;
            end
            2'd2:
            begin
                cos_next = neg_sat(c_r);
                sin_next = neg_sat(s_r);
            end
            default:
            begin
                cos_next = s_r;
                sin_next = neg_sat(c_r);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

`default_nettype wire

/* design/spherical_angles_to_unit_vector.sv */
// Throughput: one beat per cycle; the pipeline holds as a whole while the output stalls.
// Reset (rst_n, async, active low) clears only the per-stage valid bits; data regs free-run.
// Depends on sau_pkg and sau_sincos (angle map + CORDIC stages), one lane per angle.
`default_nettype none

module spherical_angles_to_unit_vector #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [16:0] theta_deg, [33:17] phi_deg, pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata    // [15:0] dir_x, [31:16] dir_y, [47:32] dir_z
);
    import sau_pkg::*;

    // stages beyond the atan table are not built
    localparam int NSTG = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    // angle map 4 + CORDIC + fold 1 + product 1 + output 1
    localparam int LAT  = NSTG + 7;

    logic [LAT-1:0] vld_reg, vld_next;
    logic           en;

    logic signed [ANG_W-1:0] theta, phi;
    logic signed [OUT_W-1:0] st, ct, sp, cp;

    // product stage
    logic signed [31:0]      px_reg, px_next, py_reg, py_next;
    logic signed [OUT_W-1:0] pz_reg;
    // output stage
    logic signed [OUT_W-1:0] dx_reg, dx_next, dy_reg, dy_next, dz_reg;

    // Whole pipeline advances together whenever the output slot is empty or draining.
    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;

    assign theta = s_axis_tdata[16:0];
    assign phi   = s_axis_tdata[33:17];

    sau_sincos #(.NSTG(NSTG)) u_theta (
        .clk   (clk),
        .en    (en),
        .ang   (theta),
        .sin_q (st),
        .cos_q (ct)
    );

    sau_sincos #(.NSTG(NSTG)) u_phi (
        .clk   (clk),
        .en    (en),
        .ang   (phi),
        .sin_q (sp),
        .cos_q (cp)
    );

    // Q1.15 x Q1.15 -> Q2.30, registered before rounding
    always_comb
    begin
        px_next = st * cp;
        py_next = st * sp;
    end

    always_comb
    begin
        dx_next = rnd15_sat(WIDE_W'(px_reg));
        dy_next = rnd15_sat(WIDE_W'(py_reg));
    end

    always_comb
    begin
        vld_next = {vld_reg[LAT-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= ct;
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            dz_reg <= pz_reg;
        end
    end

    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tdata  = {dz_reg, dy_reg, dx_reg};

`ifndef NO_ASSERTIONS
    // input side only stalls when a finished beat is blocked downstream
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a blocked output beat");

    // a beat one stage from the end must show up at the output next cycle
    a_beat_arrives: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[LAT-2]) |=> m_axis_tvalid)
        else $error("beat lost in final pipeline stage");

    // draining with nothing behind must leave the output empty
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !vld_reg[LAT-2]) |=> !m_axis_tvalid)
        else $error("output beat repeated or invented");
`endif

endmodule

`default_nettype wire

/* verif/unit_vector_checker.sv */
// Direction checker: watches both stream channels, predicts each unit vector from
// the angle pair it sees accepted, and compares beat by beat. Depends on sau_pkg.
module unit_vector_checker #(
    parameter int STAGES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [16:0] theta_deg, [33:17] phi_deg, pad
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [47:0] m_axis_tdata,   // [15:0] dir_x, [31:16] dir_y, [47:32] dir_z
    output int               mismatches,
    output int               pending,
    output int               checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import sau_pkg::*;

    typedef struct packed {
        logic signed [OUT_W-1:0] z;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] x;
    } direction_t;

    // arctan(2^-i) in units of 2^-32 turn
    longint atan_turn [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    direction_t expected_dirs [$];
    int n_bad     = 0;
    int n_waiting = 0;
    int n_checked = 0;

    assign mismatches = n_bad;
    assign pending    = n_waiting;
    assign checked    = n_checked;

    function automatic longint clip16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Q9.7 degrees -> Q1.15 sine and cosine through the folded CORDIC
    function automatic void angle_sin_cos(input logic [ANG_W-1:0] raw,
                                          output longint sin_q15, output longint cos_q15);
        longint deg, x, y, z, dx, dy, c, s;
        longint unsigned turn_frac;
        logic [1:0] quad;
        int i;
        deg = longint'($signed(raw)) % FULL_TURN;
        if (deg < 0)
            deg += FULL_TURN;
        turn_frac = ((longint'(deg) << 32) + 23040) / 46080;
        quad = turn_frac[31:30];
        z = {34'd0, turn_frac[29:0]};
        x = GAIN_Q30;
        y = 0;
        for (i = 0; i < STAGES && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_turn[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_turn[i];
            end
        end
        c = clip16((x + 16384) >>> 15);
        s = clip16((y + 16384) >>> 15);
        case (quad)
            2'd0:    begin cos_q15 = c;          sin_q15 = s;          end
            2'd1:    begin cos_q15 = clip16(-s); sin_q15 = c;          end
            2'd2:    begin cos_q15 = clip16(-c); sin_q15 = clip16(-s); end
            default: begin cos_q15 = s;          sin_q15 = clip16(-c); end
        endcase
    endfunction

    function automatic direction_t predict_direction(input logic [39:0] beat);
        longint st, ct, sp, cp;
        direction_t d;
        angle_sin_cos(beat[16:0], st, ct);
        angle_sin_cos(beat[33:17], sp, cp);
        d.x = 16'(clip16((st * cp + 16384) >>> 15));
        d.y = 16'(clip16((st * sp + 16384) >>> 15));
        d.z = 16'(ct);
        return d;
    endfunction

    // pop before push: a stray output must never match the pair accepted this edge
    always @(posedge clk) begin
        direction_t want, got;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (expected_dirs.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("[%0t] unexpected direction beat %h", $realtime, got);
                end else begin
                    want = expected_dirs.pop_front();
                    n_waiting--;
                    n_checked++;
                    if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("[%0t] dir mismatch: exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                                     $realtime, want.x, want.y, want.z, got.x, got.y, got.z);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_dirs.push_back(predict_direction(s_axis_tdata));
                n_waiting++;
            end
        end
    end

endmodule

/* verif/tb_spherical_angles_to_unit_vector.sv */
// Top of the spherical-angle testbench: clock, reset, angle-pair stimulus, output
// throttling and the verdict. Depends on sau_pkg, the block and unit_vector_checker.
module tb_spherical_angles_to_unit_vector;
    timeunit 1ns;
    timeprecision 1ps;

    import sau_pkg::*;

    localparam int STAGES       = 16;
    localparam int LATENCY      = STAGES + 7;
    localparam int TAIL_CYCLES  = LATENCY + 20;
    // slowest correct run is roughly 1700 beats plus holds; keep a big margin
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_BEATS  = 400;
    localparam int BURST_BEATS  = 80;
    localparam int HOLD_CYCLES  = 300;
    localparam int N_DIRECTED   = 21;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;     // [16:0] theta_deg, [33:17] phi_deg, pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;           // [15:0] dir_x, [31:16] dir_y, [47:32] dir_z

    int mismatches, pending, checked;
    int idle_pct   = 0;    // chance per cycle that the sender holds back
    int stall_pct  = 0;    // chance per cycle that the receiver drops tready
    int hold_left  = 0;    // long receiver hold-off, counted down by the receiver
    int pairs_sent = 0;
    int cycle_count = 0;

    // Directed pairs in Q9.7 degrees: zero, the quadrant axes (where sin or cos hits
    // +1.0 and saturates), both range ends, one-LSB angles around zero, and raw
    // 17-bit patterns beyond +-360 that must still wrap.
    int dir_theta [0:N_DIRECTED-1] = '{
        0, 11520, 11520, 11520, 11520, 23040, 46079, -46080, -46080, 46079,
        1, -1, 5760, -11520, 34560, 65535, -65536, 46080, -23040, 11519, -34560
    };
    int dir_phi [0:N_DIRECTED-1] = '{
        0, 0, 11520, 23040, 34560, 0, 46079, -46080, 46079, -46080,
        -1, 1, 5760, -5760, 23040, -65536, 65535, -46081, 11521, 22, -1
    };

    spherical_angles_to_unit_vector #(
        .CORDIC_STAGES (STAGES)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    unit_vector_checker #(
        .STAGES (STAGES)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .pending       (pending),
        .checked       (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random tready per cycle, or held low while a hold-off is running.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: a stuck handshake or a lost beat ends here.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Offer one angle pair after a random idle gap and wait for its beat.
    // With no gap tvalid stays high, so it is never lowered and raised in one step.
    task automatic send_pair(input logic [ANG_W-1:0] theta, input logic [ANG_W-1:0] phi);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, phi, theta};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pairs_sent++;
    endtask

    // Mostly uniform over +-360, a share hugging the quadrant axes where the fold
    // and saturation matter, and a few raw 17-bit patterns past the range.
    function automatic logic [ANG_W-1:0] random_angle();
        int pick, v;
        pick = $urandom_range(99);
        if (pick < 70)
            v = int'($urandom_range(92159)) - FULL_TURN;
        else if (pick < 94)
            v = (int'($urandom_range(7)) - 4) * 11520 + int'($urandom_range(16)) - 8;
        else
            v = int'($urandom);
        return v[ANG_W-1:0];
    endfunction

    task automatic run_phase(input int sender_idle, input int receiver_stall);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        repeat (PHASE_BEATS)
            send_pair(random_angle(), random_angle());
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners, full rate both sides
        for (int i = 0; i < N_DIRECTED; i++)
            send_pair(dir_theta[i][ANG_W-1:0], dir_phi[i][ANG_W-1:0]);

        run_phase(0, 0);
        run_phase(55, 0);
        run_phase(0, 55);

        // backpressure burst: receiver stops long enough for the pipe to fill
        // and push back on the sender, which keeps offering beats
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = HOLD_CYCLES;
        repeat (BURST_BEATS)
            send_pair(random_angle(), random_angle());

        // sender goes quiet until every outstanding vector has come back
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);

        run_phase(29, 29);

        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Summary: %0d angle pairs (directed corners, four throttle mixes, a hold-off burst),",
                 pairs_sent);
        $display("         %0d direction beats compared, %0d mismatches.", checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
